[sv/rmmfc_pkg.sv]
`default_nettype none
package rmmfc_pkg;

  // Field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ASZ_W      = 2;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SIZE_REG_W = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned LANES      = 4;

  // Command codes; the top command code behaves as a debug read
  localparam logic [CMD_W-1:0] CMD_READ        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE       = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEBUG       = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DEBUG_ALIAS = 2'd3;

  // Access size codes; the top size code behaves as a word
  localparam logic [ASZ_W-1:0] SIZE_BYTE       = 2'd0;
  localparam logic [ASZ_W-1:0] SIZE_HALF       = 2'd1;
  localparam logic [ASZ_W-1:0] SIZE_WORD       = 2'd2;
  localparam logic [ASZ_W-1:0] SIZE_WORD_ALIAS = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_BASE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SIZE = 2'd3;

  // Number of bytes moved by one access
  function automatic logic [2:0] size_bytes(input logic [ASZ_W-1:0] asz);
    logic [2:0] n;
    case (asz)
      SIZE_BYTE: n = 3'd1;
      SIZE_HALF: n = 3'd2;
      default:   n = 3'd4;
    endcase
    return n;
  endfunction

  // All ones over the bytes of one access
  function automatic logic [DATA_W-1:0] size_mask(input logic [ASZ_W-1:0] asz);
    logic [DATA_W-1:0] m;
    case (asz)
      SIZE_BYTE: m = 32'h0000_00FF;
      SIZE_HALF: m = 32'h0000_FFFF;
      default:   m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

[sv/rmmfc_ifs.sv]
`default_nettype none
// Access request channel
interface rmmfc_req_if;
  import rmmfc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ASZ_W-1:0]  access_size;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;
  modport source (output valid, cmd, access_size, address, write_data, input ready);
  modport sink   (input valid, cmd, access_size, address, write_data, output ready);
endinterface

// Access response channel
interface rmmfc_rsp_if;
  import rmmfc_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              status;
  logic [ADDR_W-1:0] last_fault;
  modport source (output valid, read_data, status, last_fault, input ready);
  modport sink   (input valid, read_data, status, last_fault, output ready);
endinterface

// Configuration write channel
interface rmmfc_cfg_if;
  import rmmfc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/rmmfc_byte_ram.sv]
`default_nettype none
// Single-port byte RAM, one byte lane of the region storage
module rmmfc_byte_ram #(
  parameter int unsigned Depth = 32768,
  parameter int unsigned AddrW = 15
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [7:0]       wdata_i,
  output logic      [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  // Write or registered read, one access per cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[sv/region_mapped_memory_with_fault_capture_top.sv]
`default_nettype none
// Channel  | Dir | Modport | Payload
// ---------+-----+---------+---------------------------------------------
// req_i    | in  | sink    | cmd, access_size, address, write_data
// rsp_o    | out | source  | read_data, status, last_fault
// cfg_i    | in  | sink    | index (0..3), data
//
// One access per cycle sustained while rsp_o.ready stays high; a result is offered
// once its transfer in has passed the input register, then the byte-lane RAM read register.
// After reset the storage is zeroed one row of four bytes per cycle, over all
// RegionBytes/2 rows, with req_i.ready low; cfg_i is taken meanwhile.
// A stalled response holds the input register, which then holds req_i.ready.
module region_mapped_memory_with_fault_capture_top #(
  parameter int unsigned RegionBytes = 65536
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rmmfc_req_if.sink  req_i,
  rmmfc_rsp_if.source rsp_o,
  rmmfc_cfg_if.sink  cfg_i
);
  import rmmfc_pkg::*;

  localparam int unsigned TotalBytes = 2 * RegionBytes;
  localparam int unsigned IdxW       = $clog2(TotalBytes);
  localparam int unsigned OffW       = $clog2(RegionBytes);
  localparam int unsigned Rows       = (TotalBytes + 3) / 4;
  localparam int unsigned RowW       = $clog2(Rows);
  localparam int unsigned SizeMaxInt = (1 << SIZE_REG_W) - 1;
  localparam int unsigned SizeCapInt = (RegionBytes < SizeMaxInt) ? RegionBytes : SizeMaxInt;
  localparam logic [SIZE_REG_W-1:0] SizeCap  = SIZE_REG_W'(SizeCapInt);
  localparam logic [RowW-1:0]       LastRow  = RowW'(Rows - 1);
  localparam logic [IdxW-1:0]       Region1At = IdxW'(RegionBytes);

  // Configuration registers (sizes stored already clamped to the storage)
  logic [ADDR_W-1:0]     base0_q, base1_q;
  logic [SIZE_REG_W-1:0] size0_q, size1_q;
  logic [SIZE_REG_W-1:0] cfg_size;

  assign cfg_i.ready = 1'b1;
  assign cfg_size = (cfg_i.data[SIZE_REG_W-1:0] > SizeCap) ? SizeCap
                                                           : cfg_i.data[SIZE_REG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base0_q <= '0;
      base1_q <= '0;
      size0_q <= '0;
      size1_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_FIRST_BASE:  base0_q <= cfg_i.data;
        CFG_FIRST_SIZE:  size0_q <= cfg_size;
        CFG_SECOND_BASE: base1_q <= cfg_i.data;
        CFG_SECOND_SIZE: size1_q <= cfg_size;
        default: ;
      endcase
    end
  end

  // Storage clearing sweep after reset
  logic            clr_q;
  logic [RowW-1:0] clr_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_row_q <= '0;
    end else if (clr_q) begin
      clr_row_q <= clr_row_q + RowW'(1);
      if (clr_row_q == LastRow) begin
        clr_q <= 1'b0;
      end
    end
  end

  // Stage A: input register
  logic              a_vld_q;
  logic [CMD_W-1:0]  a_cmd_q;
  logic [ASZ_W-1:0]  a_asz_q;
  logic [ADDR_W-1:0] a_addr_q;
  logic [DATA_W-1:0] a_wdata_q;
  logic              b_vld_q;
  logic              adv_a;
  logic              req_xfer;

  assign adv_a       = a_vld_q && (!b_vld_q || rsp_o.ready);
  assign req_i.ready = !clr_q && (!a_vld_q || adv_a);
  assign req_xfer    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (req_xfer) begin
      a_vld_q <= 1'b1;
    end else if (adv_a) begin
      a_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      a_cmd_q   <= req_i.cmd;
      a_asz_q   <= req_i.access_size;
      a_addr_q  <= req_i.address;
      a_wdata_q <= req_i.write_data;
    end
  end

  // Region match: both ranges compared in parallel at 33 bits, region 0 first
  logic [2:0]        a_nbytes;
  logic              a_debug, a_write;
  logic [ADDR_W:0]   lo0, hi0, lo1, hi1, a_beg, a_end;
  logic              in0, in1, fit0, fit1, a_hit;
  logic [ADDR_W-1:0] off_full;
  logic [IdxW-1:0]   a_idx;

  assign a_nbytes = size_bytes(a_asz_q);
  assign a_debug  = a_cmd_q inside {CMD_DEBUG, CMD_DEBUG_ALIAS};
  assign a_write  = (a_cmd_q == CMD_WRITE);
  assign lo0      = {1'b0, base0_q};
  assign lo1      = {1'b0, base1_q};
  assign hi0      = lo0 + (ADDR_W + 1)'(size0_q);
  assign hi1      = lo1 + (ADDR_W + 1)'(size1_q);
  assign a_beg    = {1'b0, a_addr_q};
  assign a_end    = a_beg + (ADDR_W + 1)'(a_nbytes);
  assign in0      = (a_beg >= lo0) && (a_beg < hi0);
  assign in1      = (a_beg >= lo1) && (a_beg < hi1);
  assign fit0     = (a_end <= hi0);
  assign fit1     = (a_end <= hi1);
  assign a_hit    = in0 ? fit0 : (in1 && fit1);
  assign off_full = in0 ? (a_addr_q - base0_q) : (a_addr_q - base1_q);
  assign a_idx    = IdxW'(off_full[OffW-1:0]) + (in0 ? '0 : Region1At);

  // Byte lanes: lane b holds storage bytes whose index is b modulo 4
  logic [LANES-1:0]       lane_en;
  logic [LANES-1:0][7:0]  lane_wbyte;
  logic [LANES-1:0][7:0]  lane_rdata;
  logic [RowW-1:0]        lane_row [LANES];
  logic [LANES-1:0]       bank_en;
  logic                   bank_we;
  logic [IdxW-1:0]        a_row_base;

  assign a_row_base = a_idx >> 2;
  assign bank_we    = clr_q || a_write;

  for (genvar b = 0; b < LANES; b++) begin : g_lane
    logic [1:0]      pos;
    logic [IdxW-1:0] row_full;

    assign pos           = 2'(b) - a_idx[1:0];
    assign lane_en[b]    = a_hit && ({1'b0, pos} < a_nbytes);
    assign row_full      = a_row_base + ((2'(b) < a_idx[1:0]) ? IdxW'(1) : '0);
    assign lane_row[b]   = row_full[RowW-1:0];
    assign lane_wbyte[b] = a_wdata_q[8*pos +: 8];
    assign bank_en[b]    = clr_q || (adv_a && lane_en[b]);

    rmmfc_byte_ram #(
      .Depth(Rows),
      .AddrW(RowW)
    ) u_ram (
      .clk_i  (clk_i),
      .en_i   (bank_en[b]),
      .we_i   (bank_we),
      .addr_i (clr_q ? clr_row_q : lane_row[b]),
      .wdata_i(clr_q ? 8'h00 : lane_wbyte[b]),
      .rdata_o(lane_rdata[b])
    );
  end

  // Fault address capture
  logic [ADDR_W-1:0] fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q <= '0;
    end else if (adv_a && !a_hit && !a_debug) begin
      fault_q <= a_addr_q;
    end
  end

  // Stage B: result register alongside the lane read registers
  logic             b_hit_q, b_debug_q, b_write_q;
  logic [1:0]       b_lo_q;
  logic [ASZ_W-1:0] b_asz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv_a) begin
      b_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      b_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      b_hit_q   <= a_hit;
      b_debug_q <= a_debug;
      b_write_q <= a_write;
      b_lo_q    <= a_idx[1:0];
      b_asz_q   <= a_asz_q;
    end
  end

  // Rotate lanes back into little-endian byte order
  logic [LANES-1:0][7:0] rd_bytes;
  logic [DATA_W-1:0]     b_mask;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rd_bytes[i] = lane_rdata[2'(b_lo_q + 2'(i))];
    end
  end

  assign b_mask = size_mask(b_asz_q);

  assign rsp_o.valid      = b_vld_q;
  assign rsp_o.status     = !b_hit_q;
  assign rsp_o.last_fault = fault_q;
  assign rsp_o.read_data  = !b_hit_q ? (b_debug_q ? b_mask : '0)
                                     : (b_write_q ? '0 : (rd_bytes & b_mask));

  // Checks
  a_no_req_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clr_q |-> !req_i.ready)
    else $error("request taken during storage clear");

  a_fault_captured: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (adv_a && !a_hit && !a_debug) |=> (fault_q == $past(a_addr_q)))
    else $error("faulting address not captured");

  a_lane_count: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    a_vld_q |-> ($countones(lane_en) <= int'(a_nbytes)))
    else $error("more byte lanes enabled than bytes in access");

  a_ram_access_gated: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (|bank_en) |-> (adv_a || clr_q))
    else $error("byte RAM accessed while pipeline stalled");

endmodule
`default_nettype wire
